FILE: design/gccl_pkg.sv
package gccl_pkg;

   // Default build-time sizes.
   localparam int unsigned DEF_AXES       = 2;
   localparam int unsigned DEF_COUNT_BITS = 12;

   // Fixed field widths.
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned PERIOD_W = 31;
   localparam int unsigned COUNT_W  = 13;
   localparam int unsigned ID_W     = 24;
   localparam int unsigned CELL_W   = 12;
   localparam int unsigned CORNER_W = 2;
   localparam int unsigned CSR_IDX_W = 3;

   // Smallest usable grid point count on any axis.
   localparam int unsigned MIN_COUNT = 2;

   // Register values after reset.
   localparam logic [COORD_W-1:0]  RST_LOWER  = '0;
   localparam logic [PERIOD_W-1:0] RST_PERIOD = 31'd65536;
   localparam logic [COUNT_W-1:0]  RST_COUNT  = 13'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOWER_X  = 3'd0,
      CSR_LOWER_Y  = 3'd1,
      CSR_PERIOD_X = 3'd2,
      CSR_PERIOD_Y = 3'd3,
      CSR_COUNT_X  = 3'd4,
      CSR_COUNT_Y  = 3'd5
   } csr_index_type;

   // Grid description of one axis as the locator sees it.
   typedef struct packed {
      logic [COORD_W-1:0]  lower;
      logic [PERIOD_W-1:0] period;
      logic [COUNT_W-1:0]  count;
   } axis_cfg_type;

   // Count clamped to the range 2 .. 2**bits.
   function automatic logic [16:0] eff_count(input logic [COUNT_W-1:0] count,
                                             input logic [4:0] bits);
      logic [16:0] cap;
      logic [16:0] result;
      cap = 17'(1) << bits;
      if (count < COUNT_W'(MIN_COUNT)) begin
         result = 17'(MIN_COUNT);
      end else if (17'(count) > cap) begin
         result = cap;
      end else begin
         result = 17'(count);
      end
      return result;
   endfunction

endpackage

FILE: design/gccl_axis_locate.sv
module gccl_axis_locate #(
   parameter int unsigned COUNT_BITS = gccl_pkg::DEF_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [31:0]            coord,
   input  gccl_pkg::axis_cfg_type cfg,
   output logic                   out_valid,
   output logic [COUNT_BITS-1:0]  out_index
);

   localparam int unsigned QB  = COUNT_BITS;
   localparam int unsigned TW  = QB + gccl_pkg::PERIOD_W;
   localparam int unsigned WW  = QB + 32;

   logic [gccl_pkg::PERIOD_W-1:0] per_eff;
   logic [QB:0]                   n_eff;
   logic [QB-1:0]                 nm2;

   // Stage 1: offset from the lower bound and the saturation threshold.
   logic        s1_valid_ff;
   logic [32:0] s1_diff_ff, s1_diff_in;
   logic [TW-1:0] s1_thr_ff, s1_thr_in;

   // Divider pipeline: element 0 is the compare stage, then one quotient bit per stage.
   logic [QB:0]    div_valid_ff, div_valid_in;
   logic [31:0]    div_rem_ff [0:QB];
   logic [31:0]    div_rem_in [0:QB];
   logic [QB-1:0]  div_quo_ff [0:QB];
   logic [QB-1:0]  div_quo_in [0:QB];
   logic [QB:0]    div_over_ff, div_over_in;

   logic          out_valid_ff;
   logic [QB-1:0] out_index_ff, out_index_in;

   logic          nonpos;
   logic [WW-1:0] trial;

   always_comb begin
      per_eff = (cfg.period == '0) ? gccl_pkg::PERIOD_W'(1) : cfg.period;
      n_eff   = (QB+1)'(gccl_pkg::eff_count(cfg.count, 5'(QB)));
      nm2     = QB'(n_eff - (QB+1)'(gccl_pkg::MIN_COUNT));
      s1_diff_in = {coord[31], coord} - {cfg.lower[31], cfg.lower};
      s1_thr_in  = nm2 * per_eff;
   end

   always_comb begin
      nonpos = s1_diff_ff[32] || (s1_diff_ff == '0);
      div_valid_in[0] = s1_valid_ff;
      // A point at or below the lower bound divides zero and lands on index 0.
      div_rem_in[0]   = nonpos ? '0 : s1_diff_ff[31:0];
      div_quo_in[0]   = '0;
      div_over_in[0]  = !nonpos && (WW'(s1_diff_ff[31:0]) >= WW'(s1_thr_ff));
      trial = '0;
      for (int s = 0; s < QB; s++) begin
         trial = WW'(per_eff) << (QB - 1 - s);
         div_valid_in[s+1] = div_valid_ff[s];
         div_over_in[s+1]  = div_over_ff[s];
         div_quo_in[s+1]   = div_quo_ff[s];
         if (WW'(div_rem_ff[s]) >= trial) begin
            div_rem_in[s+1] = div_rem_ff[s] - trial[31:0];
            div_quo_in[s+1][QB-1-s] = 1'b1;
         end else begin
            div_rem_in[s+1] = div_rem_ff[s];
         end
      end
      out_index_in = div_over_ff[QB] ? nm2 : div_quo_ff[QB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         div_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         div_valid_ff <= div_valid_in;
         out_valid_ff <= div_valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      s1_diff_ff   <= s1_diff_in;
      s1_thr_ff    <= s1_thr_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_over_ff  <= div_over_in;
      out_index_ff <= out_index_in;
   end

   assign out_valid = out_valid_ff;
   assign out_index = out_index_ff;

endmodule

FILE: design/gccl_corner_gen.sv
module gccl_corner_gen #(
   parameter int unsigned AXES       = gccl_pkg::DEF_AXES,
   parameter int unsigned COUNT_BITS = gccl_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [COUNT_BITS-1:0]             index_x,
   input  logic [COUNT_BITS-1:0]             index_y,
   input  logic [gccl_pkg::COUNT_W-1:0]      count_y,
   output logic                              rsp_valid,
   output logic [gccl_pkg::ID_W-1:0]         rsp_corner_id,
   output logic [gccl_pkg::CORNER_W-1:0]     rsp_corner_number,
   output logic [gccl_pkg::CELL_W-1:0]       rsp_cell_x,
   output logic [gccl_pkg::CELL_W-1:0]       rsp_cell_y,
   output logic                              rsp_last_corner
);

   localparam int unsigned QB       = COUNT_BITS;
   localparam int unsigned BW       = 2 * QB + 1;
   localparam int unsigned IDW      = 2 * QB + 2;
   localparam int unsigned NCORNERS = 1 << AXES;
   localparam logic [gccl_pkg::CORNER_W-1:0] LAST_CORNER = gccl_pkg::CORNER_W'(NCORNERS - 1);

   // Multiply stage: row base of the cell and the stride along x.
   logic          m_valid_ff;
   logic [BW-1:0] m_base_ff, m_base_in;
   logic [QB:0]   m_stride_ff, m_stride_in;
   logic [QB-1:0] m_ix_ff, m_iy_ff;

   // Corner sequencer. The data in the multiply stage holds until the next item,
   // which cannot arrive before the last corner of this one has gone out.
   logic                          active_ff, active_in;
   logic [gccl_pkg::CORNER_W-1:0] cnt_ff, cnt_in;
   logic [gccl_pkg::CORNER_W-1:0] cur;
   logic                          emit;
   logic                          x_add, y_add;
   logic [IDW-1:0]                id_full;

   logic                              rsp_valid_ff;
   logic [gccl_pkg::ID_W-1:0]         rsp_id_ff;
   logic [gccl_pkg::CORNER_W-1:0]     rsp_num_ff;
   logic [gccl_pkg::CELL_W-1:0]       rsp_cx_ff, rsp_cy_ff;
   logic                              rsp_last_ff;

   always_comb begin
      m_stride_in = (AXES > 1) ? (QB+1)'(gccl_pkg::eff_count(count_y, 5'(QB))) : (QB+1)'(1);
      m_base_in   = index_x * m_stride_in;
   end

   always_comb begin
      emit  = m_valid_ff || active_ff;
      cur   = m_valid_ff ? '0 : cnt_ff;
      x_add = (AXES > 1) ? cur[1] : cur[0];
      y_add = (AXES > 1) ? cur[0] : 1'b0;
      id_full = IDW'(m_base_ff)
              + (x_add ? IDW'(m_stride_ff) : '0)
              + ((AXES > 1) ? IDW'(m_iy_ff) : '0)
              + IDW'(y_add);
      active_in = emit && (cur != LAST_CORNER);
      cnt_in    = active_in ? cur + gccl_pkg::CORNER_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= in_valid;
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         m_base_ff   <= m_base_in;
         m_stride_ff <= m_stride_in;
         m_ix_ff     <= index_x;
         m_iy_ff     <= index_y;
      end
      rsp_id_ff   <= gccl_pkg::ID_W'(id_full);
      rsp_num_ff  <= cur;
      rsp_cx_ff   <= gccl_pkg::CELL_W'(m_ix_ff);
      rsp_cy_ff   <= (AXES > 1) ? gccl_pkg::CELL_W'(m_iy_ff) : '0;
      rsp_last_ff <= (cur == LAST_CORNER);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_corner_id     = rsp_id_ff;
   assign rsp_corner_number = rsp_num_ff;
   assign rsp_cell_x        = rsp_cx_ff;
   assign rsp_cell_y        = rsp_cy_ff;
   assign rsp_last_corner   = rsp_last_ff;

endmodule

FILE: design/grid_cell_corner_locator.sv
// Locates the cell of a regular 2-D grid that holds a signed Q16.16 point and
// returns the flat vertex IDs of its four corners, one transfer per cycle on
// rsp_valid, corner 0 to 3, with rsp_last_corner on the fourth. A point is taken
// when start is high and busy is low; busy then stays high while a gap counter
// runs down, so points are spaced by the four corner transfers, and a new point
// can be taken while earlier ones are still in flight. Each axis finds its index
// with a divider that yields one quotient bit per stage. The receiver cannot
// hold results off, and none is ever dropped. The csr_ registers may only be
// written while no point is in flight.
module grid_cell_corner_locator #(
   parameter int unsigned AXES       = gccl_pkg::DEF_AXES,
   parameter int unsigned COUNT_BITS = gccl_pkg::DEF_COUNT_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [gccl_pkg::COORD_W-1:0]          req_coord_x,
   input  logic [gccl_pkg::COORD_W-1:0]          req_coord_y,
   output logic                                  rsp_valid,
   output logic [gccl_pkg::ID_W-1:0]             rsp_corner_id,
   output logic [gccl_pkg::CORNER_W-1:0]         rsp_corner_number,
   output logic [gccl_pkg::CELL_W-1:0]           rsp_cell_x,
   output logic [gccl_pkg::CELL_W-1:0]           rsp_cell_y,
   output logic                                  rsp_last_corner,
   input  logic                                  csr_write,
   input  logic [gccl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gccl_pkg::COORD_W-1:0]          csr_data
);

   localparam int unsigned NCORNERS = 1 << AXES;

   logic [gccl_pkg::COORD_W-1:0]  lower_x_ff, lower_y_ff;
   logic [gccl_pkg::PERIOD_W-1:0] period_x_ff, period_y_ff;
   logic [gccl_pkg::COUNT_W-1:0]  count_x_ff, count_y_ff;

   logic       accept;
   logic [1:0] gap_ff, gap_in;

   logic                         in_valid_ff;
   logic [gccl_pkg::COORD_W-1:0] in_x_ff, in_y_ff;

   gccl_pkg::axis_cfg_type cfg_x, cfg_y;

   logic                  ax_x_valid, ax_y_valid;
   logic [COUNT_BITS-1:0] ax_x_index, ax_y_index;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_x_ff  <= gccl_pkg::RST_LOWER;
         lower_y_ff  <= gccl_pkg::RST_LOWER;
         period_x_ff <= gccl_pkg::RST_PERIOD;
         period_y_ff <= gccl_pkg::RST_PERIOD;
         count_x_ff  <= gccl_pkg::RST_COUNT;
         count_y_ff  <= gccl_pkg::RST_COUNT;
      end else if (csr_write) begin
         case (gccl_pkg::csr_index_type'(csr_index))
            gccl_pkg::CSR_LOWER_X:  lower_x_ff  <= csr_data;
            gccl_pkg::CSR_LOWER_Y:  lower_y_ff  <= csr_data;
            gccl_pkg::CSR_PERIOD_X: period_x_ff <= csr_data[gccl_pkg::PERIOD_W-1:0];
            gccl_pkg::CSR_PERIOD_Y: period_y_ff <= csr_data[gccl_pkg::PERIOD_W-1:0];
            gccl_pkg::CSR_COUNT_X:  count_x_ff  <= csr_data[gccl_pkg::COUNT_W-1:0];
            gccl_pkg::CSR_COUNT_Y:  count_y_ff  <= csr_data[gccl_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Admission: one point per corner sequence keeps the output free of collisions.
   always_comb begin
      busy   = (gap_ff != '0);
      accept = start && !busy;
      if (accept) begin
         gap_in = 2'(NCORNERS - 1);
      end else if (gap_ff != '0) begin
         gap_in = gap_ff - 2'd1;
      end else begin
         gap_in = gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff      <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         gap_ff      <= gap_in;
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_x_ff <= req_coord_x;
         in_y_ff <= req_coord_y;
      end
   end

   assign cfg_x = '{lower: lower_x_ff, period: period_x_ff, count: count_x_ff};
   assign cfg_y = '{lower: lower_y_ff, period: period_y_ff, count: count_y_ff};

   gccl_axis_locate #(
      .COUNT_BITS (COUNT_BITS)
   ) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .coord     (in_x_ff),
      .cfg       (cfg_x),
      .out_valid (ax_x_valid),
      .out_index (ax_x_index)
   );

   gccl_axis_locate #(
      .COUNT_BITS (COUNT_BITS)
   ) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .coord     (in_y_ff),
      .cfg       (cfg_y),
      .out_valid (ax_y_valid),
      .out_index (ax_y_index)
   );

   gccl_corner_gen #(
      .AXES       (AXES),
      .COUNT_BITS (COUNT_BITS)
   ) u_corner_gen (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (ax_x_valid),
      .index_x           (ax_x_index),
      .index_y           (ax_y_index),
      .count_y           (count_y_ff),
      .rsp_valid         (rsp_valid),
      .rsp_corner_id     (rsp_corner_id),
      .rsp_corner_number (rsp_corner_number),
      .rsp_cell_x        (rsp_cell_x),
      .rsp_cell_y        (rsp_cell_y),
      .rsp_last_corner   (rsp_last_corner)
   );

`ifndef SYNTHESIS
   // Both axis pipelines must stay in lockstep.
   a_axes_aligned: assert property (@(posedge clock) disable iff (reset)
      ax_y_valid == ax_x_valid)
      else $error("axis pipelines out of step");

   // A taken point must close admission for the next cycle.
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("admission not closed after a transfer");

   // Corners of one cell go out back to back and in order.
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_corner_number != '0)) |->
         ($past(rsp_valid) &&
          (rsp_corner_number == 2'($past(rsp_corner_number) + 2'd1))))
      else $error("corner sequence broken");
`endif

endmodule
